// ===== hdl/rlh_pkg.sv =====
// Shared constants, register codes and controller/datapath bundles for the
// read length histogram statistics block. No dependencies.
`default_nettype none

package rlh_pkg;

   // Histogram geometry and counter width
   localparam int LENGTH_BITS = 16;
   localparam int COUNT_WIDTH = 48;
   localparam int BIN_COUNT   = 1 << LENGTH_BITS;

   // Fixed field widths
   localparam int FLAG_W     = 16;
   localparam int LEN_W      = 31;
   localparam int BASE_W     = 56;
   localparam int OUT_CNT_W  = 48;
   localparam int BIN_OUT_W  = 16;
   localparam int PCT_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Weighted quantile arithmetic: running sum saturates at floor((2^64-1)/100),
   // which needs 58 bits, so sum*100 always fits in 64 bits.
   localparam int          PROD_W  = LENGTH_BITS + COUNT_WIDTH;
   localparam int          CUM_W   = 58;
   localparam logic [63:0] CUM_CAP = 64'd184467440737095516;
   localparam int          TGT_W   = PCT_W + BASE_W;
   localparam int          MCUM_W  = COUNT_WIDTH + LENGTH_BITS;

   // Request opcodes
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXCLUDE_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_A_PCT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_B_PCT  = 2'd2;

   localparam logic [FLAG_W-1:0] EXCLUDE_MASK_RST = 16'h0900;
   localparam logic [PCT_W-1:0]  QUANT_A_PCT_RST  = 7'd50;
   localparam logic [PCT_W-1:0]  QUANT_B_PCT_RST  = 7'd90;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

   typedef struct packed {
      logic                   add_go;     // add record accepted this cycle
      logic                   prep;       // latch scan targets, clear scan sums
      logic                   q_rd;       // downward quantile read at scan_addr
      logic                   m_rd;       // upward median read at scan_addr
      logic                   mem_clear;  // write zero at scan_addr
      logic                   load_out;   // load result register, clear stats
      logic [LENGTH_BITS-1:0] scan_addr;
   } rlh_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } rlh_stat_type;

endpackage

`default_nettype wire

// ===== hdl/rlh_req_if.sv =====
// Request channel: one read record or a finish command.
// Depends on rlh_pkg.
`default_nettype none

interface rlh_req_if;
   import rlh_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [FLAG_W-1:0] record_flag;
   logic [LEN_W-1:0]  seq_length;

   modport source (output valid, output cmd, output record_flag, output seq_length,
                   input ready);
   modport sink   (input valid, input cmd, input record_flag, input seq_length,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/rlh_rsp_if.sv =====
// Response channel: one statistics report per finish command.
// Depends on rlh_pkg.
`default_nettype none

interface rlh_rsp_if;
   import rlh_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [OUT_CNT_W-1:0] seen_count;
   logic [OUT_CNT_W-1:0] used_count;
   logic [OUT_CNT_W-1:0] filtered_count;
   logic [OUT_CNT_W-1:0] empty_count;
   logic [BASE_W-1:0]    base_total;
   logic [LEN_W-1:0]     shortest;
   logic [LEN_W-1:0]     longest;
   logic [BIN_OUT_W-1:0] median_length;
   logic [BIN_OUT_W-1:0] quantile_a_length;
   logic [BIN_OUT_W-1:0] quantile_b_length;

   modport source (output valid, output status, output seen_count, output used_count,
                   output filtered_count, output empty_count, output base_total,
                   output shortest, output longest, output median_length,
                   output quantile_a_length, output quantile_b_length,
                   input ready);
   modport sink   (input valid, input status, input seen_count, input used_count,
                   input filtered_count, input empty_count, input base_total,
                   input shortest, input longest, input median_length,
                   input quantile_a_length, input quantile_b_length,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/rlh_csr_if.sv =====
// Register write channel: index and data.
// Depends on rlh_pkg.
`default_nettype none

interface rlh_csr_if;
   import rlh_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rlh_ram.sv =====
// Generic simple dual port RAM: one write port, one read port, registered
// read returning the old contents on a same-address write. No dependencies.
`default_nettype none

module rlh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

// ===== hdl/rlh_ctrl.sv =====
// Sequencer for the read length statistics block: clear sweep, record
// intake, downward quantile scan, upward median/clear scan, report.
// Depends on rlh_pkg.
`default_nettype none

module rlh_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_cmd,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rlh_pkg::rlh_cmd_type       cmd,
   input  wire rlh_pkg::rlh_stat_type stat
);
   import rlh_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_RUN, ST_PREP, ST_QSCAN, ST_QDRAIN, ST_MSCAN, ST_MDRAIN, ST_LOAD
   } state_type;

   localparam logic [LENGTH_BITS-1:0] TOP_BIN = '1;

   state_type              state_ff, state_in;
   logic [LENGTH_BITS-1:0] scan_ff, scan_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;

   assign req_ready = (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd            = '0;
      cmd.scan_addr  = scan_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_clear = 1'b1;
            scan_in       = scan_ff + 1'b1;
            if (scan_ff == TOP_BIN) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (accept) begin
               if (req_cmd == CMD_FINISH) begin
                  state_in = ST_PREP;
               end else begin
                  cmd.add_go = 1'b1;
               end
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            scan_in  = TOP_BIN;
            state_in = ST_QSCAN;
         end
         ST_QSCAN: begin
            cmd.q_rd = 1'b1;
            scan_in  = scan_ff - 1'b1;
            if (scan_ff == '0) begin
               state_in = ST_QDRAIN;
            end
         end
         ST_QDRAIN: begin
            if (!stat.pipe_busy) begin
               scan_in  = '0;
               state_in = ST_MSCAN;
            end
         end
         ST_MSCAN: begin
            // median pass also zeroes each bin right after reading it
            cmd.m_rd      = 1'b1;
            cmd.mem_clear = 1'b1;
            scan_in       = scan_ff + 1'b1;
            if (scan_ff == TOP_BIN) begin
               state_in = ST_MDRAIN;
            end
         end
         ST_MDRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

`default_nettype wire

// ===== hdl/rlh_dp.sv =====
// Datapath of the read length statistics block: registers, record counters,
// histogram memory with read-modify-write forwarding, scan pipelines and the
// result register. Depends on rlh_pkg and rlh_ram.
`default_nettype none

module rlh_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rlh_pkg::rlh_cmd_type           cmd,
   output rlh_pkg::rlh_stat_type               stat,
   input  wire logic [rlh_pkg::FLAG_W-1:0]     record_flag,
   input  wire logic [rlh_pkg::LEN_W-1:0]      seq_length,
   input  wire logic                           csr_we,
   input  wire logic [rlh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rlh_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [rlh_pkg::STATUS_W-1:0]        status,
   output logic [rlh_pkg::OUT_CNT_W-1:0]       seen_count,
   output logic [rlh_pkg::OUT_CNT_W-1:0]       used_count,
   output logic [rlh_pkg::OUT_CNT_W-1:0]       filtered_count,
   output logic [rlh_pkg::OUT_CNT_W-1:0]       empty_count,
   output logic [rlh_pkg::BASE_W-1:0]          base_total,
   output logic [rlh_pkg::LEN_W-1:0]           shortest,
   output logic [rlh_pkg::LEN_W-1:0]           longest,
   output logic [rlh_pkg::BIN_OUT_W-1:0]       median_length,
   output logic [rlh_pkg::BIN_OUT_W-1:0]       quantile_a_length,
   output logic [rlh_pkg::BIN_OUT_W-1:0]       quantile_b_length
);
   import rlh_pkg::*;

   localparam logic [LENGTH_BITS-1:0] TOP_BIN = '1;
   localparam int CAP_XW  = COUNT_WIDTH + OUT_CNT_W;
   localparam int BIN_XW  = LENGTH_BITS + BIN_OUT_W;
   localparam int PROD_XW = PROD_W + 64;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [OUT_CNT_W-1:0] cap_out(input logic [COUNT_WIDTH-1:0] v);
      logic [CAP_XW-1:0] x;
      logic [CAP_XW-1:0] m;
      x = CAP_XW'(v);
      m = CAP_XW'({OUT_CNT_W{1'b1}});
      return (x > m) ? {OUT_CNT_W{1'b1}} : x[OUT_CNT_W-1:0];
   endfunction

   function automatic logic [BIN_OUT_W-1:0] fit_bin(input logic [LENGTH_BITS-1:0] b);
      logic [BIN_XW-1:0] x;
      x = BIN_XW'(b);
      return x[BIN_OUT_W-1:0];
   endfunction

   // ---------------- registers
   logic [FLAG_W-1:0] excl_ff;
   logic [PCT_W-1:0]  pct_a_ff, pct_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         excl_ff  <= EXCLUDE_MASK_RST;
         pct_a_ff <= QUANT_A_PCT_RST;
         pct_b_ff <= QUANT_B_PCT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXCLUDE_MASK: excl_ff  <= csr_data;
            CSR_QUANT_A_PCT:  pct_a_ff <= csr_data[PCT_W-1:0];
            CSR_QUANT_B_PCT:  pct_b_ff <= csr_data[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- record intake
   logic [COUNT_WIDTH-1:0] seen_ff, used_ff, filt_ff, empty_ff;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [BASE_W:0]        base_sum;
   logic [LEN_W-1:0]       min_ff, max_ff;
   logic                   ovf_ff;
   logic                   filt, len_zero, len_over;
   logic [LENGTH_BITS-1:0] bin_now;

   assign filt     = |(record_flag & excl_ff);
   assign len_zero = (seq_length == '0);
   assign len_over = |seq_length[LEN_W-1:LENGTH_BITS];
   assign bin_now  = len_over ? TOP_BIN : seq_length[LENGTH_BITS-1:0];
   assign base_sum = {1'b0, base_ff} + (BASE_W+1)'(seq_length);
   assign base_in  = base_sum[BASE_W] ? {BASE_W{1'b1}} : base_sum[BASE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         seen_ff  <= '0;
         used_ff  <= '0;
         filt_ff  <= '0;
         empty_ff <= '0;
         base_ff  <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.add_go) begin
         seen_ff <= sat_inc(seen_ff);
         if (filt) begin
            filt_ff <= sat_inc(filt_ff);
         end else if (len_zero) begin
            empty_ff <= sat_inc(empty_ff);
         end else begin
            used_ff <= sat_inc(used_ff);
            base_ff <= base_in;
            if (seq_length < min_ff) begin
               min_ff <= seq_length;
            end
            if (seq_length > max_ff) begin
               max_ff <= seq_length;
            end
            if (len_over) begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------- histogram memory
   logic                   a1_vld_ff;
   logic [LENGTH_BITS-1:0] a1_bin_ff;
   logic                   wb_vld_ff;
   logic [LENGTH_BITS-1:0] wb_bin_ff;
   logic [COUNT_WIDTH-1:0] wb_data_ff;
   logic [COUNT_WIDTH-1:0] hist_old, hist_new, ram_rdata, ram_wdata;
   logic [LENGTH_BITS-1:0] ram_waddr, ram_raddr;
   logic                   ram_we;

   // previous cycle's write is not yet visible in the read data
   assign hist_old  = (wb_vld_ff && (wb_bin_ff == a1_bin_ff)) ? wb_data_ff : ram_rdata;
   assign hist_new  = sat_inc(hist_old);
   assign ram_we    = a1_vld_ff || cmd.mem_clear;
   assign ram_waddr = a1_vld_ff ? a1_bin_ff : cmd.scan_addr;
   assign ram_wdata = a1_vld_ff ? hist_new : '0;
   assign ram_raddr = cmd.add_go ? bin_now : cmd.scan_addr;

   rlh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BIN_COUNT)
   ) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_vld_ff <= 1'b0;
         wb_vld_ff <= 1'b0;
      end else begin
         a1_vld_ff <= cmd.add_go && !filt && !len_zero;
         wb_vld_ff <= a1_vld_ff;
      end
      a1_bin_ff  <= bin_now;
      wb_bin_ff  <= a1_bin_ff;
      wb_data_ff <= hist_new;
   end

   // ---------------- downward weighted quantile scan
   logic                   q1_vld_ff, q2_vld_ff, q3_vld_ff, q4_vld_ff;
   logic [LENGTH_BITS-1:0] q1_bin_ff, q2_bin_ff, q3_bin_ff, q4_bin_ff;
   logic                   q2_nz_ff, q3_nz_ff, q4_nz_ff;
   logic [PROD_W-1:0]      q2_prod_ff;
   logic [PROD_XW-1:0]     prod_x;
   logic [CUM_W-1:0]       w_sat, cum_ff, cum_in;
   logic [CUM_W:0]         cum_sum;
   logic [63:0]            cum_x, q4_c100_ff;
   logic [TGT_W-1:0]       tgt_a_ff, tgt_b_ff;
   logic                   found_a_ff, found_b_ff;
   logic [LENGTH_BITS-1:0] qa_bin_ff, qb_bin_ff;
   logic                   hit_a, hit_b;

   assign prod_x  = PROD_XW'(q2_prod_ff);
   assign w_sat   = (prod_x > PROD_XW'(CUM_CAP)) ? CUM_CAP[CUM_W-1:0] : prod_x[CUM_W-1:0];
   assign cum_sum = (CUM_W+1)'(cum_ff) + (CUM_W+1)'(w_sat);
   assign cum_in  = (cum_sum >= (CUM_W+1)'(CUM_CAP)) ? CUM_CAP[CUM_W-1:0]
                                                     : cum_sum[CUM_W-1:0];
   assign cum_x   = 64'(cum_ff);
   // empty bins never end the scan, which matters when the target is zero
   assign hit_a   = q4_vld_ff && q4_nz_ff && (q4_c100_ff >= 64'(tgt_a_ff));
   assign hit_b   = q4_vld_ff && q4_nz_ff && (q4_c100_ff >= 64'(tgt_b_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_vld_ff <= 1'b0;
         q2_vld_ff <= 1'b0;
         q3_vld_ff <= 1'b0;
         q4_vld_ff <= 1'b0;
      end else begin
         q1_vld_ff <= cmd.q_rd;
         q2_vld_ff <= q1_vld_ff;
         q3_vld_ff <= q2_vld_ff;
         q4_vld_ff <= q3_vld_ff;
      end
      q1_bin_ff  <= cmd.scan_addr;
      q2_bin_ff  <= q1_bin_ff;
      q2_nz_ff   <= (ram_rdata != '0);
      q2_prod_ff <= PROD_W'(q1_bin_ff) * PROD_W'(ram_rdata);
      q3_bin_ff  <= q2_bin_ff;
      q3_nz_ff   <= q2_nz_ff;
      q4_bin_ff  <= q3_bin_ff;
      q4_nz_ff   <= q3_nz_ff;
      q4_c100_ff <= (cum_x << 6) + (cum_x << 5) + (cum_x << 2);
      if (cmd.prep) begin
         tgt_a_ff   <= TGT_W'(pct_a_ff) * TGT_W'(base_ff);
         tgt_b_ff   <= TGT_W'(pct_b_ff) * TGT_W'(base_ff);
         cum_ff     <= '0;
         found_a_ff <= 1'b0;
         found_b_ff <= 1'b0;
         qa_bin_ff  <= '0;
         qb_bin_ff  <= '0;
      end else begin
         if (q2_vld_ff) begin
            cum_ff <= cum_in;
         end
         if (hit_a && !found_a_ff) begin
            found_a_ff <= 1'b1;
            qa_bin_ff  <= q4_bin_ff;
         end
         if (hit_b && !found_b_ff) begin
            found_b_ff <= 1'b1;
            qb_bin_ff  <= q4_bin_ff;
         end
      end
   end

   // ---------------- upward median scan
   logic                   m1_vld_ff, m2_vld_ff;
   logic [LENGTH_BITS-1:0] m1_bin_ff, m2_bin_ff;
   logic [MCUM_W-1:0]      mcum_ff;
   logic [COUNT_WIDTH-1:0] mtgt_ff;
   logic                   found_m_ff;
   logic [LENGTH_BITS-1:0] med_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= cmd.m_rd;
         m2_vld_ff <= m1_vld_ff;
      end
      m1_bin_ff <= cmd.scan_addr;
      m2_bin_ff <= m1_bin_ff;
      if (cmd.prep) begin
         mtgt_ff    <= (used_ff >> 1) + COUNT_WIDTH'(used_ff[0]);
         mcum_ff    <= '0;
         found_m_ff <= 1'b0;
         med_bin_ff <= '0;
      end else begin
         if (m1_vld_ff) begin
            mcum_ff <= mcum_ff + MCUM_W'(ram_rdata);
         end
         if (m2_vld_ff && !found_m_ff && (mcum_ff >= MCUM_W'(mtgt_ff))) begin
            found_m_ff <= 1'b1;
            med_bin_ff <= m2_bin_ff;
         end
      end
   end

   assign stat.pipe_busy = q1_vld_ff || q2_vld_ff || q3_vld_ff || q4_vld_ff ||
                           m1_vld_ff || m2_vld_ff;

   // ---------------- result register
   logic none_used;
   assign none_used = (used_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         status            <= none_used ? STATUS_NONE : (ovf_ff ? STATUS_OVER : STATUS_OK);
         seen_count        <= cap_out(seen_ff);
         used_count        <= cap_out(used_ff);
         filtered_count    <= cap_out(filt_ff);
         empty_count       <= cap_out(empty_ff);
         base_total        <= base_ff;
         shortest          <= none_used ? '0 : min_ff;
         longest           <= none_used ? '0 : max_ff;
         median_length     <= fit_bin(med_bin_ff);
         quantile_a_length <= fit_bin(qa_bin_ff);
         quantile_b_length <= fit_bin(qb_bin_ff);
      end
   end
endmodule

`default_nettype wire

// ===== hdl/read_length_histogram_nx_stats.sv =====
// Top level of the read length statistics block: channel interfaces,
// sequencer and datapath. Depends on rlh_pkg, rlh_*_if, rlh_ctrl, rlh_dp.
//
//   channel | dir | handshake   | payload
//   req_ch  | in  | valid/ready | cmd, record_flag, seq_length
//   rsp_ch  | out | valid/ready | status, counts, base_total, min/max, median, quantiles
//   csr_ch  | in  | valid/ready | index, data (ready always high)
//
// Add records are taken one per cycle while the sequencer is in its run state;
// the histogram update is a read-modify-write through one memory with forwarding
// of the last write. A finish, once accepted, runs one downward sweep of the
// histogram memory for both quantiles, then one upward sweep for the median that
// also zeroes every bin, before rsp_ch.valid rises. After reset a clear sweep of
// every bin runs with req_ch.ready low. The report sits in an output register;
// records keep flowing while it waits, and the next report waits until the
// previous is taken.
`default_nettype none

module read_length_histogram_nx_stats (
   input  wire logic  clock,
   input  wire logic  reset,
   rlh_req_if.sink    req_ch,
   rlh_rsp_if.source  rsp_ch,
   rlh_csr_if.sink    csr_ch
);
   import rlh_pkg::*;

   rlh_cmd_type  cmd;
   rlh_stat_type stat;
   logic         req_ready;
   logic         rsp_valid;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

   rlh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rlh_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .record_flag       (req_ch.record_flag),
      .seq_length        (req_ch.seq_length),
      .csr_we            (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .status            (rsp_ch.status),
      .seen_count        (rsp_ch.seen_count),
      .used_count        (rsp_ch.used_count),
      .filtered_count    (rsp_ch.filtered_count),
      .empty_count       (rsp_ch.empty_count),
      .base_total        (rsp_ch.base_total),
      .shortest          (rsp_ch.shortest),
      .longest           (rsp_ch.longest),
      .median_length     (rsp_ch.median_length),
      .quantile_a_length (rsp_ch.quantile_a_length),
      .quantile_b_length (rsp_ch.quantile_b_length)
   );
endmodule

`default_nettype wire
